// File: rtl/scu_pkg.sv
// ----------------------------------------------------------------------------
// Serial card package
// Shared types and constants of the serial card UART and its baud timer.
// ----------------------------------------------------------------------------
package scu_pkg;

	localparam int RxDepth = 3;
	localparam int CyclesPerUnit = 128;
	localparam int LvlW = $clog2(RxDepth + 1);
	localparam int IdxW = (RxDepth > 1) ? $clog2(RxDepth) : 1;
	localparam int CntW = 16 + $clog2(CyclesPerUnit) + 1;

	localparam logic [7:0] HiSer = 8'hFA;
	localparam logic [7:0] HiTmr = 8'hFB;
	localparam logic [7:0] LoFirst = 8'hDC;
	localparam logic [7:0] LoLast = 8'hDF;
	localparam logic [7:0] Rr0Base = 8'h20;
	localparam logic [7:0] BitRxAvail = 8'h01;
	localparam logic [7:0] BitTxEmpty = 8'h04;
	localparam logic [7:0] BitDcd = 8'h08;
	localparam logic [7:0] BitFrame = 8'h08;
	localparam logic [7:0] BitOverrun = 8'h10;

	localparam logic [1:0] RxHunt = 2'd0;
	localparam logic [1:0] RxStart = 2'd1;
	localparam logic [1:0] RxData = 2'd2;
	localparam logic [1:0] RxStop = 2'd3;

	localparam logic [2:0] CmdChanReset = 3'd3;
	localparam logic [2:0] CmdErrReset = 3'd6;

	localparam logic [1:0] AccLatch = 2'd0;
	localparam logic [1:0] AccLow = 2'd1;
	localparam logic [1:0] AccHigh = 2'd2;
	localparam logic [1:0] AccBoth = 2'd3;

	typedef struct packed {
		logic        line_rx;
		logic        io_request;
		logic        fetch_cycle;
		logic        read_strobe;
		logic        write_strobe;
		logic [15:0] bus_address;
		logic [7:0]  bus_write_data;
		logic        host_byte_valid;
		logic [7:0]  host_byte;
	} in_t;

	typedef struct packed {
		logic       line_tx;
		logic [7:0] read_data;
		logic       read_drive;
		logic       tx_echo_valid;
		logic [7:0] tx_echo_byte;
		logic       quiet;
	} out_t;

endpackage

// File: rtl/serial_card_uart_with_baud_timer.sv
// ----------------------------------------------------------------------------
// Serial card UART with baud timer
// 8N1 channel with a 3-deep receive queue and a three-counter baud timer.
// ----------------------------------------------------------------------------
// Each input beat is one master cycle of the emulated card. The in channel
// carries the line sample, the processor strobes, the address and write data
// and an optional host byte push. The out channel returns one result beat per
// input beat: transmit line level, read data and drive, the transmit echo and
// the quiet flag. The cfg channel writes the plugged bit; it is always ready.
// The core does the whole cycle's work between the input handshake and the
// result register. Throughput is one beat per cycle while the skid is empty;
// a new beat is taken while the previous result waits, since the result
// register and a one-entry skid buffer part the two sides. When the receiver
// stalls, the skid fills and in_stall rises only once both are occupied.
// Reset leaves the card unplugged, the transmitter idle at mark, the receiver
// hunting, the queue empty and all three timer counters in low/high mode.
// ----------------------------------------------------------------------------
module serial_card_uart_with_baud_timer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  scu_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output scu_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	logic plugged_q;
	logic step;
	scu_pkg::out_t res;
	scu_pkg::out_t skid_q;
	logic skid_valid_q;

	// The in side stalls only when both output slots hold a beat.
	assign in_stall = skid_valid_q;
	assign step = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plugged_q <= 1'b0;
		else if (cfg_valid) plugged_q <= cfg_data;
	end

	scu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.plugged (plugged_q),
		.item    (in_data),
		.res     (res)
	);

	// Output register plus skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid || !out_stall) begin
				out_valid <= skid_valid_q || step;
				skid_valid_q <= 1'b0;
			end else if (step) skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || !out_stall) out_data <= skid_valid_q ? skid_q : res;
		if (out_valid && out_stall && step) skid_q <= res;
	end

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid)
		else $error("skid holds a beat ahead of output");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> !skid_valid_q)
		else $error("skid not drained");

endmodule

// File: rtl/scu_core.sv
// ----------------------------------------------------------------------------
// Serial card core
// One master cycle of line and bus work: state update and result in one pass.
// ----------------------------------------------------------------------------
module scu_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           plugged,
	input  scu_pkg::in_t   item,
	output scu_pkg::out_t  res
);

	logic [2:0] ptr_a_q, ptr_b_q;
	logic [7:0] err_q;
	logic [7:0] queue_q [scu_pkg::RxDepth];
	logic [scu_pkg::LvlW-1:0] lvl_q;
	logic [7:0] hold_q;
	logic hfull_q;
	logic [9:0] frame_q;
	logic [3:0] txrem_q;
	logic [scu_pkg::CntW-1:0] txcnt_q, rxcnt_q;
	logic txlvl_q;
	logic [1:0] rxph_q;
	logic [7:0] asm_q;
	logic [3:0] rxidx_q;
	logic rxprev_q;
	logic [15:0] reload_q [3];
	logic [15:0] latch_q [3];
	logic [2:0] latched_q, wtog_q, rtog_q;
	logic [1:0] acc_q [3];
	logic sprev_q, quiet_q;
	logic [7:0] rhold_q;

	logic [2:0] ptr_a_d, ptr_b_d;
	logic [7:0] err_d;
	logic [7:0] queue_d [scu_pkg::RxDepth];
	logic [scu_pkg::LvlW-1:0] lvl_d;
	logic [7:0] hold_d;
	logic hfull_d;
	logic [9:0] frame_d;
	logic [3:0] txrem_d;
	logic [scu_pkg::CntW-1:0] txcnt_d, rxcnt_d, period;
	logic txlvl_d;
	logic [1:0] rxph_d;
	logic [7:0] asm_d;
	logic [3:0] rxidx_d;
	logic rxprev_d;
	logic [15:0] reload_d [3];
	logic [15:0] latch_d [3];
	logic [2:0] latched_d, wtog_d, rtog_d;
	logic [1:0] acc_d [3];
	logic sprev_d;
	logic [7:0] rhold_d;
	scu_pkg::out_t res_d;

	logic [7:0] hi, lo, v;
	logic [1:0] off, sel_t, rl;
	logic io, sel, edg, ser, hib;
	logic [15:0] tv;

	always_comb begin
		ptr_a_d = ptr_a_q; ptr_b_d = ptr_b_q; err_d = err_q;
		queue_d = queue_q; lvl_d = lvl_q; hold_d = hold_q; hfull_d = hfull_q;
		frame_d = frame_q; txrem_d = txrem_q; txcnt_d = txcnt_q; txlvl_d = txlvl_q;
		rxph_d = rxph_q; asm_d = asm_q; rxidx_d = rxidx_q; rxcnt_d = rxcnt_q;
		rxprev_d = rxprev_q; reload_d = reload_q; latch_d = latch_q;
		latched_d = latched_q; wtog_d = wtog_q; rtog_d = rtog_q; acc_d = acc_q;
		sprev_d = sprev_q; rhold_d = rhold_q;
		res_d = '0;
		res_d.line_tx = 1'b1;
		hi = item.bus_address[15:8];
		lo = item.bus_address[7:0];
		off = lo[1:0] - scu_pkg::LoFirst[1:0];
		io = 1'b0; sel = 1'b0; edg = 1'b0; ser = 1'b0; hib = 1'b0;
		sel_t = '0; rl = '0; tv = '0; v = '0;
		period = (reload_q[0] == 16'd0) ? scu_pkg::CntW'(scu_pkg::CyclesPerUnit)
			: scu_pkg::CntW'(reload_q[0]) * scu_pkg::CntW'(scu_pkg::CyclesPerUnit);

		if (item.host_byte_valid) begin
			if (lvl_d >= scu_pkg::LvlW'(scu_pkg::RxDepth)) err_d = err_d | scu_pkg::BitOverrun;
			else begin
				queue_d[lvl_d[scu_pkg::IdxW-1:0]] = item.host_byte;
				lvl_d = lvl_d + 1'b1;
			end
		end

		if (plugged) begin
			// transmitter
			if (txrem_d == 4'd0 && !hfull_d) txlvl_d = 1'b1;
			else begin
				if (txrem_d == 4'd0) begin
					frame_d = {1'b1, hold_d, 1'b0};
					txrem_d = 4'd10; txcnt_d = '0; hfull_d = 1'b0;
				end
				txlvl_d = frame_d[0];
				txcnt_d = txcnt_d + 1'b1;
				if (txcnt_d >= period) begin
					txcnt_d = '0;
					frame_d = frame_d >> 1;
					txrem_d = txrem_d - 1'b1;
					if (txrem_d == 4'd0) txlvl_d = 1'b1;
				end
			end
			// receiver
			case (rxph_d)
				scu_pkg::RxHunt: begin
					if (rxprev_d && !item.line_rx) begin
						rxph_d = scu_pkg::RxStart; rxcnt_d = '0;
					end
				end
				scu_pkg::RxStart: begin
					rxcnt_d = rxcnt_d + 1'b1;
					if (rxcnt_d >= (period >> 1)) begin
						if (!item.line_rx) begin
							rxph_d = scu_pkg::RxData; rxcnt_d = '0;
							asm_d = '0; rxidx_d = '0;
						end else rxph_d = scu_pkg::RxHunt;
					end
				end
				scu_pkg::RxData: begin
					rxcnt_d = rxcnt_d + 1'b1;
					if (rxcnt_d >= period) begin
						rxcnt_d = '0;
						asm_d = {item.line_rx, asm_d[7:1]};
						rxidx_d = rxidx_d + 1'b1;
						if (rxidx_d >= 4'd8) rxph_d = scu_pkg::RxStop;
					end
				end
				default: begin
					rxcnt_d = rxcnt_d + 1'b1;
					if (rxcnt_d >= period) begin
						if (item.line_rx) begin
							if (lvl_d >= scu_pkg::LvlW'(scu_pkg::RxDepth))
								err_d = err_d | scu_pkg::BitOverrun;
							else begin
								queue_d[lvl_d[scu_pkg::IdxW-1:0]] = asm_d;
								lvl_d = lvl_d + 1'b1;
							end
						end else err_d = err_d | scu_pkg::BitFrame;
						rxph_d = scu_pkg::RxHunt; rxcnt_d = '0;
					end
				end
			endcase
			rxprev_d = item.line_rx;
			res_d.line_tx = txlvl_d;

			// bus decode
			io = item.io_request && !item.fetch_cycle && (item.read_strobe || item.write_strobe);
			sel = io && (hi == scu_pkg::HiSer || hi == scu_pkg::HiTmr)
				&& lo >= scu_pkg::LoFirst && lo <= scu_pkg::LoLast;
			edg = sel && !sprev_q;
			sprev_d = sel;
			ser = (hi == scu_pkg::HiSer);
			if (sel) begin
				if (item.read_strobe) begin
					if (edg) begin
						if (ser) begin
							case (off)
								2'd0: begin
									if (lvl_d == '0) rhold_d = '0;
									else begin
										rhold_d = queue_d[0];
										for (int i = 0; i < scu_pkg::RxDepth - 1; i++)
											queue_d[i] = queue_d[i + 1];
										lvl_d = lvl_d - 1'b1;
									end
								end
								2'd2: begin
									ptr_a_d = '0;
									if (ptr_a_q == 3'd1) begin
										rhold_d = err_d;
										if (!hfull_d && txrem_d == 4'd0) rhold_d[0] = 1'b1;
									end else if (ptr_a_q == 3'd2) rhold_d = '0;
									else begin
										rhold_d = scu_pkg::Rr0Base;
										if (lvl_d != '0) rhold_d = rhold_d | scu_pkg::BitRxAvail;
										if (!hfull_d)
											rhold_d = rhold_d | scu_pkg::BitTxEmpty | scu_pkg::BitDcd;
									end
								end
								default: rhold_d = '0;
							endcase
						end else if (off == 2'd3) rhold_d = '0;
						else begin
							tv = latched_d[off] ? latch_d[off] : reload_d[off];
							hib = acc_d[off] == scu_pkg::AccHigh
								|| (acc_d[off] == scu_pkg::AccBoth && rtog_d[off]);
							rhold_d = hib ? tv[15:8] : tv[7:0];
							if (acc_d[off] == scu_pkg::AccLow || acc_d[off] == scu_pkg::AccHigh)
								latched_d[off] = 1'b0;
							else if (!rtog_d[off]) rtog_d[off] = 1'b1;
							else begin
								rtog_d[off] = 1'b0; latched_d[off] = 1'b0;
							end
						end
					end
					res_d.read_data = rhold_d;
					res_d.read_drive = 1'b1;
				end else if (edg) begin
					v = item.bus_write_data;
					if (ser) begin
						if (off == 2'd0) begin
							hold_d = v; hfull_d = 1'b1;
							res_d.tx_echo_valid = 1'b1; res_d.tx_echo_byte = v;
						end else if (off == 2'd2) begin
							if (ptr_a_d == 3'd0) begin
								ptr_a_d = v[2:0];
								if (v[5:3] == scu_pkg::CmdChanReset) begin
									ptr_a_d = '0; err_d = '0; lvl_d = '0; hfull_d = 1'b0;
									txrem_d = '0; txcnt_d = '0; txlvl_d = 1'b1;
									rxph_d = scu_pkg::RxHunt;
								end
								if (v[5:3] == scu_pkg::CmdErrReset) err_d = '0;
							end else ptr_a_d = '0;
						end else if (off == 2'd3) begin
							ptr_b_d = (ptr_b_d == 3'd0) ? v[2:0] : 3'd0;
						end
					end else if (off == 2'd3) begin
						sel_t = v[7:6]; rl = v[5:4];
						if (sel_t != 2'd3) begin
							if (rl == scu_pkg::AccLatch) begin
								latch_d[sel_t] = reload_d[sel_t]; latched_d[sel_t] = 1'b1;
							end else begin
								acc_d[sel_t] = rl; wtog_d[sel_t] = 1'b0; rtog_d[sel_t] = 1'b0;
							end
						end
					end else begin
						if (acc_d[off] == scu_pkg::AccLow
							|| (acc_d[off] != scu_pkg::AccHigh && !wtog_d[off]))
							reload_d[off][7:0] = v;
						else reload_d[off][15:8] = v;
						if (acc_d[off] != scu_pkg::AccLow && acc_d[off] != scu_pkg::AccHigh)
							wtog_d[off] = !wtog_d[off];
					end
				end
			end
		end
		res_d.quiet = txrem_d == 4'd0 && !hfull_d && rxph_d == scu_pkg::RxHunt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_a_q <= '0; ptr_b_q <= '0; err_q <= '0; lvl_q <= '0;
			hold_q <= '0; hfull_q <= 1'b0; frame_q <= '0; txrem_q <= '0;
			txcnt_q <= '0; txlvl_q <= 1'b1; rxph_q <= scu_pkg::RxHunt;
			asm_q <= '0; rxidx_q <= '0; rxcnt_q <= '0; rxprev_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				reload_q[i] <= '0; latch_q[i] <= '0; acc_q[i] <= scu_pkg::AccBoth;
			end
			latched_q <= '0; wtog_q <= '0; rtog_q <= '0;
			sprev_q <= 1'b0; rhold_q <= '0; quiet_q <= 1'b1;
		end else if (step) begin
			ptr_a_q <= ptr_a_d; ptr_b_q <= ptr_b_d; err_q <= err_d; lvl_q <= lvl_d;
			hold_q <= hold_d; hfull_q <= hfull_d; frame_q <= frame_d; txrem_q <= txrem_d;
			txcnt_q <= txcnt_d; txlvl_q <= txlvl_d; rxph_q <= rxph_d;
			asm_q <= asm_d; rxidx_q <= rxidx_d; rxcnt_q <= rxcnt_d; rxprev_q <= rxprev_d;
			reload_q <= reload_d; latch_q <= latch_d; acc_q <= acc_d;
			latched_q <= latched_d; wtog_q <= wtog_d; rtog_q <= rtog_d;
			sprev_q <= sprev_d; rhold_q <= rhold_d; quiet_q <= res_d.quiet;
		end
	end

	always_ff @(posedge clk) begin
		if (step) queue_q <= queue_d;
	end

	assign res = res_d;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= scu_pkg::LvlW'(scu_pkg::RxDepth))
		else $error("queue level past depth");
	a_quiet_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		quiet_q |-> (rxph_q == scu_pkg::RxHunt && txrem_q == 4'd0))
		else $error("quiet with line busy");
	a_txrem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		txrem_q <= 4'd10)
		else $error("frame bit count out of range");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Serial card UART testbench
// Runs the card through directed and random beats and checks every result.
// ----------------------------------------------------------------------------
// The card is driven one master cycle per input beat. The testbench predicts
// every result beat: transmit line, read data and drive, transmit echo and
// the quiet flag. Each accepted result is compared with the oldest
// prediction. The plugged bit is written only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;

	// Port offsets within the serial controller and timer windows.
	localparam logic [7:0] OffDataA = 8'd0;
	localparam logic [7:0] OffDataB = 8'd1;
	localparam logic [7:0] OffCtrlA = 8'd2;
	localparam logic [7:0] OffCtrlB = 8'd3;
	localparam logic [7:0] OffTmrCtl = 8'd3;
	// Read register numbers selected by the control pointer.
	localparam logic [2:0] RegStatus1 = 3'd1;
	localparam logic [2:0] RegVector = 3'd2;
	localparam int StallLimit = 4000;

	// Predicts the card cycle by cycle and holds the result beats still due.
	class card_scoreboard;
		bit plugged;
		logic [2:0] ptr_a, ptr_b;
		logic [7:0] errors;
		logic [7:0] rxq[scu_pkg::RxDepth];
		int rxq_level;
		logic [7:0] hold_byte;
		bit hold_full;
		logic [9:0] frame;
		int tx_left;
		int unsigned tx_ticks;
		bit tx_line;
		logic [1:0] rx_state;
		logic [7:0] rx_bits;
		int rx_index;
		int unsigned rx_ticks;
		bit rx_last;
		logic [15:0] reload[3], latch[3];
		bit latched[3], wtog[3], rtog[3];
		logic [1:0] access[3];
		bit sel_last;
		logic [7:0] read_byte;
		scu_pkg::out_t due[$];
		int failures;

		function new();
			plugged = 0; ptr_a = 0; ptr_b = 0; errors = 0; rxq_level = 0;
			hold_byte = 0; hold_full = 0; frame = 0; tx_left = 0; tx_ticks = 0;
			tx_line = 1; rx_state = scu_pkg::RxHunt; rx_bits = 0; rx_index = 0;
			rx_ticks = 0; rx_last = 1; sel_last = 0; read_byte = 0;
			failures = 0;
			for (int i = 0; i < 3; i++) begin
				reload[i] = 0; latch[i] = 0; latched[i] = 0;
				access[i] = scu_pkg::AccBoth; wtog[i] = 0; rtog[i] = 0;
			end
			for (int i = 0; i < scu_pkg::RxDepth; i++) rxq[i] = 0;
		endfunction

		function int unsigned baud_cycles();
			return ((reload[0] == 0) ? 1 : reload[0]) * scu_pkg::CyclesPerUnit;
		endfunction

		function void enqueue(logic [7:0] v);
			if (rxq_level >= scu_pkg::RxDepth) begin
				errors |= scu_pkg::BitOverrun;
				return;
			end
			rxq[rxq_level] = v;
			rxq_level++;
		endfunction

		function logic [7:0] dequeue();
			logic [7:0] v;
			if (rxq_level == 0) return 8'h00;
			v = rxq[0];
			rxq_level--;
			for (int i = 0; i < rxq_level; i++) rxq[i] = rxq[i + 1];
			return v;
		endfunction

		function void tx_tick();
			if (tx_left == 0) begin
				if (!hold_full) begin
					tx_line = 1;
					return;
				end
				frame = {1'b1, hold_byte, 1'b0};
				tx_left = 10;
				tx_ticks = 0;
				hold_full = 0;
			end
			tx_line = frame[0];
			tx_ticks++;
			if (tx_ticks >= baud_cycles()) begin
				tx_ticks = 0;
				frame = frame >> 1;
				tx_left--;
				if (tx_left == 0) tx_line = 1;
			end
		endfunction

		function void rx_tick(bit rxd);
			int unsigned bt;
			bt = baud_cycles();
			case (rx_state)
				scu_pkg::RxHunt: begin
					if (rx_last && !rxd) begin
						rx_state = scu_pkg::RxStart;
						rx_ticks = 0;
					end
				end
				scu_pkg::RxStart: begin
					rx_ticks++;
					if (rx_ticks >= bt / 2) begin
						if (!rxd) begin
							rx_state = scu_pkg::RxData; rx_ticks = 0;
							rx_bits = 0; rx_index = 0;
						end else begin
							rx_state = scu_pkg::RxHunt;
						end
					end
				end
				scu_pkg::RxData: begin
					rx_ticks++;
					if (rx_ticks >= bt) begin
						rx_ticks = 0;
						rx_bits = {rxd, rx_bits[7:1]};
						rx_index++;
						if (rx_index >= 8) rx_state = scu_pkg::RxStop;
					end
				end
				default: begin
					rx_ticks++;
					if (rx_ticks >= bt) begin
						if (rxd) enqueue(rx_bits);
						else errors |= scu_pkg::BitFrame;
						rx_state = scu_pkg::RxHunt;
						rx_ticks = 0;
					end
				end
			endcase
			rx_last = rxd;
		endfunction

		function void control_write(bit chan_a, logic [7:0] v);
			logic [2:0] cmd;
			cmd = v[5:3];
			if (chan_a) begin
				if (ptr_a == 0) begin
					ptr_a = v[2:0];
					if (cmd == scu_pkg::CmdChanReset) begin
						ptr_a = 0; errors = 0; rxq_level = 0; hold_full = 0;
						tx_left = 0; tx_ticks = 0; tx_line = 1;
						rx_state = scu_pkg::RxHunt;
					end
					if (cmd == scu_pkg::CmdErrReset) errors = 0;
				end else begin
					ptr_a = 0;
				end
			end else begin
				ptr_b = (ptr_b == 0) ? v[2:0] : 3'd0;
			end
		endfunction

		function logic [7:0] control_read();
			logic [2:0] which;
			logic [7:0] v;
			which = ptr_a;
			ptr_a = 0;
			if (which == RegStatus1) begin
				v = errors;
				if (!hold_full && tx_left == 0) v |= scu_pkg::BitRxAvail;
				return v;
			end
			if (which == RegVector) return 8'h00;
			v = scu_pkg::Rr0Base;
			if (rxq_level > 0) v |= scu_pkg::BitRxAvail;
			if (!hold_full) v |= scu_pkg::BitTxEmpty | scu_pkg::BitDcd;
			return v;
		endfunction

		function void timer_write(logic [7:0] off, logic [7:0] v);
			logic [1:0] sel, rl;
			if (off == OffTmrCtl) begin
				sel = v[7:6];
				rl = v[5:4];
				if (sel == 2'd3) return;
				if (rl == scu_pkg::AccLatch) begin
					latch[sel] = reload[sel];
					latched[sel] = 1;
					return;
				end
				access[sel] = rl; wtog[sel] = 0; rtog[sel] = 0;
				return;
			end
			if (access[off] == scu_pkg::AccLow) begin
				reload[off][7:0] = v;
			end else if (access[off] == scu_pkg::AccHigh) begin
				reload[off][15:8] = v;
			end else if (!wtog[off]) begin
				reload[off][7:0] = v;
				wtog[off] = 1;
			end else begin
				reload[off][15:8] = v;
				wtog[off] = 0;
			end
		endfunction

		function logic [7:0] timer_read(logic [7:0] off);
			logic [15:0] val;
			bit upper;
			logic [7:0] r;
			if (off == OffTmrCtl) return 8'h00;
			val = latched[off] ? latch[off] : reload[off];
			upper = access[off] == scu_pkg::AccHigh
				|| (access[off] == scu_pkg::AccBoth && rtog[off]);
			r = upper ? val[15:8] : val[7:0];
			if (access[off] == scu_pkg::AccLow || access[off] == scu_pkg::AccHigh) begin
				latched[off] = 0;
			end else if (!rtog[off]) begin
				rtog[off] = 1;
			end else begin
				rtog[off] = 0;
				latched[off] = 0;
			end
			return r;
		endfunction

		// Whether the next write to a counter lands in its high byte.
		function bit next_write_high(int n);
			return access[n] == scu_pkg::AccHigh
				|| (access[n] == scu_pkg::AccBoth && wtog[n]);
		endfunction

		function void note_beat(scu_pkg::in_t b);
			scu_pkg::out_t e;
			logic [7:0] hi, lo, off;
			bit io, sel, first;
			e = '0;
			e.line_tx = 1;
			hi = b.bus_address[15:8];
			lo = b.bus_address[7:0];
			if (b.host_byte_valid) enqueue(b.host_byte);
			if (plugged) begin
				tx_tick();
				rx_tick(b.line_rx);
				e.line_tx = tx_line;
				io = b.io_request && !b.fetch_cycle && (b.read_strobe || b.write_strobe);
				sel = io && (hi == scu_pkg::HiSer || hi == scu_pkg::HiTmr)
					&& lo >= scu_pkg::LoFirst && lo <= scu_pkg::LoLast;
				first = sel && !sel_last;
				sel_last = sel;
				if (sel) begin
					off = lo - scu_pkg::LoFirst;
					if (b.read_strobe) begin
						if (first) begin
							if (hi == scu_pkg::HiSer) begin
								if (off == OffDataA) read_byte = dequeue();
								else if (off == OffCtrlA) read_byte = control_read();
								else read_byte = 8'h00;
							end else begin
								read_byte = timer_read(off);
							end
						end
						e.read_data = read_byte;
						e.read_drive = 1;
					end else if (first) begin
						if (hi == scu_pkg::HiSer) begin
							if (off == OffDataA) begin
								hold_byte = b.bus_write_data;
								hold_full = 1;
								e.tx_echo_valid = 1;
								e.tx_echo_byte = b.bus_write_data;
							end else if (off != OffDataB) begin
								control_write(off == OffCtrlA, b.bus_write_data);
							end
						end else begin
							timer_write(off, b.bus_write_data);
						end
					end
				end
			end
			e.quiet = tx_left == 0 && !hold_full && rx_state == scu_pkg::RxHunt;
			due.push_back(e);
		endfunction

		task report(string what, logic [7:0] got, logic [7:0] want);
			$display("error: %s got %0h expected %0h", what, got, want);
			failures++;
		endtask

		task check_beat(scu_pkg::out_t o);
			scu_pkg::out_t e;
			if (due.size() == 0) begin
				report("unexpected result beat", 8'h00, 8'h00);
				return;
			end
			e = due.pop_front();
			if (o.line_tx !== e.line_tx) report("line_tx", o.line_tx, e.line_tx);
			if (o.read_data !== e.read_data) report("read_data", o.read_data, e.read_data);
			if (o.read_drive !== e.read_drive) report("read_drive", o.read_drive, e.read_drive);
			if (o.tx_echo_valid !== e.tx_echo_valid)
				report("tx_echo_valid", o.tx_echo_valid, e.tx_echo_valid);
			if (o.tx_echo_byte !== e.tx_echo_byte)
				report("tx_echo_byte", o.tx_echo_byte, e.tx_echo_byte);
			if (o.quiet !== e.quiet) report("quiet", o.quiet, e.quiet);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	scu_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	scu_pkg::out_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;

	card_scoreboard sb = new();
	bit calm = 0;
	bit line_plan[$];
	int beats_sent = 0;
	int quiet_cycles = 0;

	serial_card_uart_with_baud_timer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// The receiver side stalls at random except during the calm stretch.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 21);
	end

	// Result checks and a watchdog that trips when no beat moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_beat(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready) || sb.due.size() == 0) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= StallLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// The receive wire follows queued frames, else rests at mark with rare glitches.
	function bit next_rx();
		if (line_plan.size() > 0) return line_plan.pop_front();
		return $urandom_range(0, 99) >= 2;
	endfunction

	function void plan_frame(logic [7:0] v, bit bad_stop);
		int unsigned bt;
		bt = sb.baud_cycles();
		repeat (bt) line_plan.push_back(1'b0);
		for (int i = 0; i < 8; i++) repeat (bt) line_plan.push_back(v[i]);
		repeat (bt) line_plan.push_back(!bad_stop);
		repeat (bt / 2) line_plan.push_back(1'b1);
	endfunction

	function scu_pkg::in_t idle_beat();
		scu_pkg::in_t b;
		b = '0;
		b.line_rx = next_rx();
		b.io_request = 1'($urandom_range(0, 1));
		b.fetch_cycle = 1'($urandom_range(0, 1));
		b.bus_address = 16'($urandom);
		b.bus_write_data = 8'($urandom);
		b.host_byte_valid = $urandom_range(0, 99) < 4;
		b.host_byte = 8'($urandom);
		return b;
	endfunction

	task automatic send_beat(input scu_pkg::in_t b);
		if (!calm && $urandom_range(0, 99) < 21) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		in_data = b;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b);
		beats_sent++;
		@(negedge clk);
	endtask

	// One processor access held for one to three beats, then released.
	task automatic bus_access(logic [7:0] hi, logic [7:0] lo, bit rd, bit wr,
	                          logic [7:0] data, bit noisy = 0);
		scu_pkg::in_t b;
		repeat ($urandom_range(1, 3)) begin
			b = idle_beat();
			b.io_request = noisy ? ($urandom_range(0, 9) != 0) : 1'b1;
			b.fetch_cycle = noisy ? ($urandom_range(0, 9) == 0) : 1'b0;
			b.read_strobe = rd;
			b.write_strobe = wr;
			b.bus_address = {hi, lo};
			b.bus_write_data = data;
			send_beat(b);
		end
		send_beat(idle_beat());
	endtask

	task automatic wait_drained();
		in_valid = 0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_plugged(bit v);
		cfg_valid = 1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.plugged = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_beats(int n);
		int r, stop_at;
		logic [7:0] lo, data;
		int n_ctr;
		stop_at = beats_sent + n;
		while (beats_sent < stop_at) begin
			if (line_plan.size() == 0 && $urandom_range(0, 99) < 5)
				plan_frame(8'($urandom), $urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_beat(idle_beat());
			end else if (r < 58) begin
				bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataA, 1, 0, 8'($urandom));
			end else if (r < 64) begin
				bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataA, 0, 1, 8'($urandom));
			end else if (r < 73) begin
				data = $urandom_range(0, 3) == 0 ? 8'($urandom)
					: {2'b00, 3'($urandom), 3'($urandom)};
				if (data[5:3] == scu_pkg::CmdChanReset && $urandom_range(0, 3) != 0)
					data[5:3] = 3'd0;
				bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA,
				           1'($urandom_range(0, 1)), 1, data);
			end else if (r < 78) begin
				lo = scu_pkg::LoFirst + ($urandom_range(0, 1) ? OffDataB : OffCtrlB);
				bus_access(scu_pkg::HiSer, lo, 1'($urandom_range(0, 1)),
				           1'($urandom_range(0, 1)), 8'($urandom));
			end else if (r < 88) begin
				// Counter 0 sets the bit time, so it stays small.
				n_ctr = $urandom_range(0, 2);
				data = 8'($urandom);
				if (n_ctr == 0) data = sb.next_write_high(0) ? 8'h00 : 8'($urandom_range(0, 2));
				bus_access(scu_pkg::HiTmr, 8'(scu_pkg::LoFirst + n_ctr),
				           $urandom_range(0, 2) == 0, 1, data);
			end else if (r < 93) begin
				bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl,
				           $urandom_range(0, 3) == 0, 1, 8'($urandom));
			end else begin
				// Noise stays clear of the timer window so the bit time stays small.
				bus_access($urandom_range(0, 1) ? scu_pkg::HiSer : 8'($urandom_range(0, 8'hF9)),
				           $urandom_range(0, 1) ? 8'(scu_pkg::LoFirst + $urandom_range(0, 3))
				                                : 8'($urandom),
				           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				           8'($urandom), 1);
			end
		end
	endtask

	task automatic directed_beats();
		scu_pkg::in_t b;
		logic [7:0] pushes[4];
		pushes = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		// The queue holds three bytes, so the fourth host byte at the latest finds it full and sets overrun.
		foreach (pushes[i]) begin
			b = idle_beat();
			b.host_byte_valid = 1;
			b.host_byte = pushes[i];
			send_beat(b);
		end
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 1, 0, 8'h00);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 0, 1, {5'd0, RegStatus1});
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 1, 0, 8'h00);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 0, 1,
		           {2'b00, scu_pkg::CmdErrReset, 3'd0});
		// Three pops drain the queue and the fourth reads an empty queue.
		repeat (4) bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataA, 1, 0, 8'h00);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 0, 1, {5'd0, RegVector});
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 1, 0, 8'h00);
		// A pointer of 6 makes the next write a discarded one.
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 0, 1, 8'h06);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlA, 0, 1,
		           {2'b00, scu_pkg::CmdChanReset, 3'd0});
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlB, 0, 1,
		           {2'b00, scu_pkg::CmdChanReset, 3'd7});
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffCtrlB, 1, 0, 8'h00);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataB, 0, 1, 8'hFF);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataB, 1, 0, 8'h00);
		// Both strobes at once count as a read.
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataA, 1, 1, 8'h77);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl, 0, 1, 8'hC0);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl, 0, 1, 8'h00);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst, 1, 0, 8'h00);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst, 1, 0, 8'h00);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl, 0, 1,
		           {2'd1, scu_pkg::AccLow, 4'd0});
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + 8'd1, 0, 1, 8'hFF);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + 8'd1, 1, 0, 8'h00);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl, 0, 1,
		           {2'd2, scu_pkg::AccHigh, 4'd0});
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + 8'd2, 0, 1, 8'h80);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + 8'd2, 1, 0, 8'h00);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl, 1, 0, 8'h00);
		// Divisor 2 while a frame goes out, then lowered to 1 in mid-bit.
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst + OffTmrCtl, 0, 1,
		           {2'd0, scu_pkg::AccBoth, 4'd0});
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst, 0, 1, 8'h02);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst, 0, 1, 8'h00);
		bus_access(scu_pkg::HiSer, scu_pkg::LoFirst + OffDataA, 0, 1, 8'h81);
		repeat (200) send_beat(idle_beat());
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst, 0, 1, 8'h01);
		bus_access(scu_pkg::HiTmr, scu_pkg::LoFirst, 0, 1, 8'h00);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Unplugged: only host pushes touch the card.
		random_beats(40);
		wait_drained();
		set_plugged(1);
		directed_beats();
		random_beats(250);
		calm = 1;
		random_beats(150);
		calm = 0;
		wait_drained();
		random_beats(100);
		wait_drained();
		set_plugged(0);
		random_beats(40);
		wait_drained();
		set_plugged(1);
		random_beats(100);
		wait_drained();
		if (sb.failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
